// ----- design/spq_pkg.sv -----
// Package for the sorted-insert priority queue: word types, codes and defaults.
package spq_pkg;

  // Default number of cells in the chain
  localparam int unsigned DepthDefault = 256;

  // Width of the fill field on the result word
  localparam int unsigned FillWidth = 9;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [31:0] weight;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  symbol;
    logic [31:0] weight;
  } in_word_t;

  typedef struct packed {
    status_e                status;
    logic [7:0]             out_symbol;
    logic [31:0]            out_weight;
    logic [FillWidth-1:0]   fill;
  } out_word_t;

  // Contents of one cell as seen by its neighbours
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } cell_data_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
// One cell of the sorted chain: holds one entry and trades it with its neighbours.
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               prev_cond_i,
  input  spq_pkg::cell_data_t prev_i,
  input  spq_pkg::cell_data_t next_i,
  output logic               cond_o,
  output spq_pkg::cell_data_t data_o
);
  import spq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  // New entry belongs at or before this cell
  assign cond_o = !valid_q || (ctrl_i.new_entry.weight <= entry_q.weight);

  // Shift up on insert, take the new entry at the boundary, shift down on remove
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (prev_cond_i) begin
        valid_d = prev_i.valid;
        entry_d = prev_i.entry;
      end else if (cond_o) begin
        valid_d = 1'b1;
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.rem) begin
      valid_d = next_i.valid;
      entry_d = next_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset: an invalid cell is never read
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = '{valid: valid_q, entry: entry_q};

endmodule

// ----- design/sorted_insert_priority_queue.sv -----
// Top level of the sorted-insert priority queue built as a chain of cells.
// Sorted priority queue of (symbol, weight) entries, lightest at the head. An insert
// places the new entry ahead of the first stored entry of equal or greater weight; a
// remove returns the head. The new weight is compared in all cells at once and each
// cell moves its entry one place along the chain on the accepting edge, so a word can
// be accepted on every cycle while results are taken. The result word appears in the
// output register on the cycle after acceptance. While that word waits untaken the
// input is held off, so a new word is taken only when the register is empty or is being
// read in the same cycle. Reset empties the queue at once; no clearing pass is needed.
module sorted_insert_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::out_word_t out_word_o
);
  import spq_pkg::*;

  localparam int unsigned CountWidth = $clog2(DEPTH + 1);

  logic [CountWidth-1:0] count_q, count_d;
  logic                  out_valid_q;
  out_word_t             out_word_q, out_word_d;
  logic                  accept;
  logic                  is_full, is_empty;
  cell_ctrl_t            ctrl;
  logic       [DEPTH-1:0] cond;
  cell_data_t [DEPTH-1:0] data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CountWidth'(DEPTH));
  assign is_empty   = (count_q == '0);

  // Broadcast the operation to the chain
  assign ctrl.ins       = accept && (in_word_i.kind == KIND_INSERT) && !is_full;
  assign ctrl.rem       = accept && (in_word_i.kind == KIND_REMOVE) && !is_empty;
  assign ctrl.new_entry = '{symbol: in_word_i.symbol, weight: in_word_i.weight};

  // Build the chain; the head has no lower neighbour, the tail takes an empty cell
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic       prev_cond;
    cell_data_t prev_data;
    cell_data_t next_data;
    if (g == 0) begin : g_head
      assign prev_cond = 1'b0;
      assign prev_data = '0;
    end else begin : g_body
      assign prev_cond = cond[g-1];
      assign prev_data = data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_link
      assign next_data = data[g+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_cond_i (prev_cond),
      .prev_i      (prev_data),
      .next_i      (next_data),
      .cond_o      (cond[g]),
      .data_o      (data[g])
    );
  end

  // Update the fill count and form the result word
  always_comb begin
    count_d    = count_q;
    out_word_d = '{status: ST_OK, out_symbol: '0, out_weight: '0, fill: '0};
    if (in_word_i.kind == KIND_INSERT) begin
      if (is_full) begin
        out_word_d.status = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (is_empty) begin
        out_word_d.status = ST_EMPTY;
      end else begin
        count_d               = count_q - 1'b1;
        out_word_d.out_symbol = data[0].entry.symbol;
        out_word_d.out_weight = data[0].entry.weight;
      end
    end
    out_word_d.fill = FillWidth'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= accept;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- design/spq_checker.sv -----
// Port-level checks for the sorted-insert priority queue, bound to the top level.
module spq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input spq_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input spq_pkg::out_word_t out_word_o
);
  import spq_pkg::*;

  // Every accepted word yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word gave no result");

  // Refused or empty operations carry no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != ST_OK) |->
      (out_word_o.out_symbol == '0) && (out_word_o.out_weight == '0))
    else $error("failed operation carried an entry");

  // An empty queue reports a fill of zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_EMPTY) |-> (out_word_o.fill == '0))
    else $error("empty status with nonzero fill");

  // A successful insert never reports an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.kind == KIND_INSERT) |=>
      (out_word_o.status == ST_FULL) || (out_word_o.fill != '0))
    else $error("insert left queue empty");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

endmodule

bind sorted_insert_priority_queue spq_checker u_spq_checker (.*);
